### hdl/adcma_pkg.sv
// Package for the converter moving-average block.
// Holds field widths, the default window length and the sequencer state type.
// Used by the top module and the checker; depends on nothing.
package adcma_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int AVG_W      = 10;
    localparam int DEF_WINDOW = 100;
    localparam int STEP_W     = $clog2(AVG_W + 1);

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

### hdl/adcma_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the sample ring store; depends on nothing.
module adcma_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/adc_moving_average_top.sv
// An accepted input passes through the update, divide and done states before its
// result is registered; no new input is taken until that result is loaded. The
// bit-serial divider retires one quotient bit per cycle.
// A finished result waits in the output register while the next input is taken.
// Reset is asynchronous and active low; it empties the window and the sum.
// The sample store holds no reset; its read data is used only after every slot is written.
module adc_moving_average_top #(
    parameter int WINDOW = adcma_pkg::DEF_WINDOW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [adcma_pkg::SAMPLE_W-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [adcma_pkg::AVG_W-1:0]   average,
    output logic                          window_full
);

    import adcma_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int DVS_W = CNT_W + AVG_W - 1;
    localparam int DIV_W = (SUM_W > DVS_W) ? SUM_W : DVS_W;

    state_t             state_reg, state_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               filled_reg, filled_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvs_reg, dvs_next;
    logic [AVG_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]   average_reg, average_next;
    logic               full_reg, full_next;

    logic [SAMPLE_W-1:0] old_sample;
    logic [SAMPLE_W-1:0] leaving;
    logic [CNT_W-1:0]    divisor;
    logic                ram_wr_en;
    logic                fits;
    logic                out_load;

    adcma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (sample_reg),
        .rd_addr (idx_reg),
        .rd_data (old_sample)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign average     = average_reg;
    assign window_full = full_reg;

    assign ram_wr_en = (state_reg == ST_UPDATE);
    assign leaving   = filled_reg ? old_sample : '0;
    assign divisor   = filled_reg ? CNT_W'(WINDOW) : (CNT_W'(idx_reg) + CNT_W'(1));
    assign fits      = (rem_reg >= dvs_reg);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        filled_next    = filled_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;
        full_next      = full_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                sum_next  = sum_reg - SUM_W'(leaving) + SUM_W'(sample_reg);
                rem_next  = DIV_W'(sum_next);
                dvs_next  = DIV_W'(divisor) << (AVG_W - 1);
                quo_next  = '0;
                step_next = STEP_W'(AVG_W);
                if (idx_reg == IDX_W'(WINDOW - 1))
                begin
                    idx_next    = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - dvs_reg;
                end
                dvs_next  = dvs_reg >> 1;
                quo_next  = {quo_reg[AVG_W-2:0], fits};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    average_next   = quo_reg;
                    full_next      = filled_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            idx_reg       <= '0;
            filled_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            filled_reg    <= filled_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        quo_reg     <= quo_next;
        average_reg <= average_next;
        full_reg    <= full_next;
    end

endmodule

### hdl/adcma_checker.sv
// Port-level checker for the converter moving-average block.
// Depends on adcma_pkg and is bound to adc_moving_average_top below.
module adcma_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [adcma_pkg::AVG_W-1:0]   average,
    input logic                          window_full
);

    import adcma_pkg::*;

    logic       full_seen_reg, full_seen_next;
    logic [1:0] pending_reg, pending_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        full_seen_next = full_seen_reg || (out_take && window_full);
        pending_next   = pending_reg + 2'(in_take) - 2'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_seen_reg <= 1'b0;
            pending_reg   <= '0;
        end
        else
        begin
            full_seen_reg <= full_seen_next;
            pending_reg   <= pending_next;
        end
    end

    // A held result stays on the port until its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(average) && $stable(window_full))
        else $error("stalled result changed or was dropped");

    // Once a full window has been reported, every later result reports it too.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_seen_reg |-> window_full)
        else $error("window_full fell after the window filled");

    // An input transaction is always followed by a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("second input taken in the cycle after a transaction");

    // No result appears without an input transaction still owed a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without a matching input transaction");

    // At most one result waits while one more item is in the datapath.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many transactions in flight");

endmodule

bind adc_moving_average_top adcma_checker u_adcma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .average     (average),
    .window_full (window_full)
);
